>>> design/gbts_pkg.sv
// Package for the gap buffer text store.
// Holds the command codes and the request and response word layouts.
// No dependencies; compile first.
package gbts_pkg;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_DELETE = 2'd1;
   localparam logic [1:0] CMD_MOVE   = 2'd2;
   localparam logic [1:0] CMD_READ   = 2'd3;

   typedef struct packed {
      logic [1:0]         command;
      logic [7:0]         char_in;
      logic [10:0]        count;
      logic signed [11:0] offset;
      logic [9:0]         read_index;
   } req_payload_type;

   typedef struct packed {
      logic signed [11:0] done_count;
      logic [7:0]         char_out;
      logic               char_valid;
      logic               full_res;
      logic [10:0]        text_length;
      logic [10:0]        cursor;
   } rsp_payload_type;

endpackage

>>> design/gbts_chan_if.sv
// Valid/ready channel interface used for the request and response words.
// The payload type is a parameter; the word types live in gbts_pkg.
interface gbts_chan_if #(parameter type payload_type = logic) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

>>> design/gap_buffer_text_store.sv
// Gap buffer text store: top level with the command sequencer and gap pointers.
// Depends on gbts_pkg, gbts_chan_if and gbts_ram.
//
//   channel   modport   word                       accepted when
//   --------  --------  -------------------------  ------------------------
//   req_chan  sink      gbts_pkg::req_payload_type  req_chan.valid & ready
//   rsp_chan  source    gbts_pkg::rsp_payload_type  rsp_chan.valid & ready
//
// One command is handled at a time. After the accepting edge, insert and
// delete go from the execute state to the response state, a read also passes
// the read-wait state for the registered RAM read, and a cursor move of n
// characters streams one character per cycle through the RAM's read and write
// ports in the move state. The block returns to idle for the next word once the
// response is taken. Reset is synchronous; the text RAM is not cleared, so no
// startup pass. A stalled response simply holds the block in its response state.
module gap_buffer_text_store #(
   parameter int CAPACITY = 1024
) (
   input  logic        clock,
   input  logic        reset,
   gbts_chan_if.sink   req_chan,
   gbts_chan_if.source rsp_chan
);

   import gbts_pkg::*;

   // Pointer width holds 0..CAPACITY; address width indexes the RAM.
   localparam int PW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);
   localparam int CW = (PW > 12) ? PW : 12;
   localparam logic [CW-1:0] CAP_CW = CW'(CAPACITY);
   localparam logic [PW-1:0] CAP_PW = PW'(CAPACITY);

   // Sequencer states.
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_EXEC   = 3'd1;
   localparam logic [2:0] ST_MOVE   = 3'd2;
   localparam logic [2:0] ST_RDWAIT = 3'd3;
   localparam logic [2:0] ST_RESP   = 3'd4;

   logic [2:0]      state_ff, state_in;
   req_payload_type req_ff, req_in;

   // Gap pointers plus the text length and gap size, kept alongside so that
   // no subtraction of the two pointers is needed on the read path.
   logic [PW-1:0] gs_ff, gs_in;
   logic [PW-1:0] ge_ff, ge_in;
   logic [PW-1:0] len_ff, len_in;
   logic [PW-1:0] gap_ff, gap_in;

   // Move streaming: characters still to read, read pointer, and a flag that
   // says a read was issued last cycle and its data must be written now.
   logic [PW-1:0] left_ff, left_in;
   logic [AW-1:0] rptr_ff, rptr_in;
   logic          pend_ff, pend_in;
   logic          back_ff, back_in;

   // Response word registers.
   logic [11:0] done_ff, done_in;
   logic [7:0]  char_ff, char_in;
   logic        valid_ff, valid_in;
   logic        full_ff, full_in;

   // RAM port signals.
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [7:0]    ram_wdata;
   logic [AW-1:0] ram_raddr;
   logic [7:0]    ram_rdata;

   // Command arithmetic, evaluated in the execute state on the latched word.
   logic [PW-1:0] gs_dec, ge_dec;
   logic [CW-1:0] gs_cw, cnt_cw, del_n;
   logic          off_neg;
   logic [11:0]   mag;
   logic [CW-1:0] mag_cw, room, mv_n, mv_neg;
   logic [CW-1:0] idx_cw, phys;
   logic          rd_ok;

   assign gs_dec  = gs_ff - 1'b1;
   assign ge_dec  = ge_ff - 1'b1;
   assign gs_cw   = CW'(gs_ff);
   assign cnt_cw  = CW'(req_ff.count);
   assign del_n   = (cnt_cw < gs_cw) ? cnt_cw : gs_cw;

   // A negative offset of -2048 still gives a correct 12-bit magnitude.
   assign off_neg = req_ff.offset[11];
   assign mag     = off_neg ? (12'd0 - $unsigned(req_ff.offset)) : $unsigned(req_ff.offset);
   assign mag_cw  = CW'(mag);
   assign room    = off_neg ? gs_cw : (CAP_CW - CW'(ge_ff));
   assign mv_n    = (mag_cw < room) ? mag_cw : room;
   assign mv_neg  = '0 - mv_n;

   // Logical to physical index: positions past the cursor skip the gap.
   assign idx_cw  = CW'(req_ff.read_index);
   assign rd_ok   = idx_cw < CW'(len_ff);
   assign phys    = (idx_cw < gs_cw) ? idx_cw : (idx_cw + CW'(gap_ff));

   always_comb begin
      state_in  = state_ff;
      req_in    = req_ff;
      gs_in     = gs_ff;
      ge_in     = ge_ff;
      len_in    = len_ff;
      gap_in    = gap_ff;
      left_in   = left_ff;
      rptr_in   = rptr_ff;
      pend_in   = 1'b0;
      back_in   = back_ff;
      done_in   = done_ff;
      char_in   = char_ff;
      valid_in  = valid_ff;
      full_in   = full_ff;
      ram_we    = 1'b0;
      ram_waddr = gs_ff[AW-1:0];
      ram_wdata = req_ff.char_in;
      ram_raddr = rptr_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               req_in   = req_chan.payload;
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            done_in  = '0;
            char_in  = '0;
            valid_in = 1'b0;
            full_in  = 1'b0;
            unique case (req_ff.command)
               CMD_INSERT: begin
                  if (gap_ff == '0) begin
                     full_in = 1'b1;
                  end else begin
                     ram_we = 1'b1;
                     gs_in  = gs_ff + 1'b1;
                     len_in = len_ff + 1'b1;
                     gap_in = gap_ff - 1'b1;
                  end
                  state_in = ST_RESP;
               end
               CMD_DELETE: begin
                  gs_in    = gs_ff - del_n[PW-1:0];
                  len_in   = len_ff - del_n[PW-1:0];
                  gap_in   = gap_ff + del_n[PW-1:0];
                  done_in  = del_n[11:0];
                  state_in = ST_RESP;
               end
               CMD_MOVE: begin
                  left_in  = mv_n[PW-1:0];
                  back_in  = off_neg;
                  rptr_in  = off_neg ? gs_dec[AW-1:0] : ge_ff[AW-1:0];
                  done_in  = off_neg ? mv_neg[11:0] : mv_n[11:0];
                  state_in = ST_MOVE;
               end
               CMD_READ: begin
                  valid_in  = rd_ok;
                  ram_raddr = phys[AW-1:0];
                  state_in  = ST_RDWAIT;
               end
               default: begin
                  state_in = ST_RESP;
               end
            endcase
         end

         ST_MOVE: begin
            // Read of the next character overlaps the write of the previous one;
            // the two addresses never meet because they lie on opposite sides
            // of the gap.
            if (left_ff != '0) begin
               left_in = left_ff - 1'b1;
               rptr_in = back_ff ? (rptr_ff - 1'b1) : (rptr_ff + 1'b1);
               pend_in = 1'b1;
            end else begin
               state_in = ST_RESP;
            end
            if (pend_ff) begin
               ram_we    = 1'b1;
               ram_wdata = ram_rdata;
               if (back_ff) begin
                  ram_waddr = ge_dec[AW-1:0];
                  gs_in     = gs_dec;
                  ge_in     = ge_dec;
               end else begin
                  ram_waddr = gs_ff[AW-1:0];
                  gs_in     = gs_ff + 1'b1;
                  ge_in     = ge_ff + 1'b1;
               end
            end
         end

         ST_RDWAIT: begin
            char_in  = valid_ff ? ram_rdata : 8'd0;
            state_in = ST_RESP;
         end

         ST_RESP: begin
            if (rsp_chan.ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         gs_ff    <= '0;
         ge_ff    <= CAP_PW;
         len_ff   <= '0;
         gap_ff   <= CAP_PW;
         left_ff  <= '0;
         pend_ff  <= 1'b0;
         back_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         gs_ff    <= gs_in;
         ge_ff    <= ge_in;
         len_ff   <= len_in;
         gap_ff   <= gap_in;
         left_ff  <= left_in;
         pend_ff  <= pend_in;
         back_ff  <= back_in;
      end
      req_ff   <= req_in;
      rptr_ff  <= rptr_in;
      done_ff  <= done_in;
      char_ff  <= char_in;
      valid_ff <= valid_in;
      full_ff  <= full_in;
   end

   gbts_ram #(
      .WIDTH (8),
      .DEPTH (CAPACITY)
   ) u_text_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_chan.valid = (state_ff == ST_RESP);

   assign rsp_chan.payload.done_count  = $signed(done_ff);
   assign rsp_chan.payload.char_out    = char_ff;
   assign rsp_chan.payload.char_valid  = valid_ff;
   assign rsp_chan.payload.full_res    = full_ff;
   assign rsp_chan.payload.text_length = 11'(len_ff);
   assign rsp_chan.payload.cursor      = 11'(gs_ff);

   // Text length and gap size always account for the whole store.
   a_len_gap: assert property (@(posedge clock) disable iff (reset)
      (CW'(len_ff) + CW'(gap_ff)) == CAP_CW)
      else $error("text length and gap size do not add up to the capacity");

   // The gap end sits exactly one gap size past the cursor.
   a_gap_ptrs: assert property (@(posedge clock) disable iff (reset)
      (CW'(gs_ff) + CW'(gap_ff)) == CW'(ge_ff))
      else $error("gap pointers disagree with the gap size");

   // Moving the cursor shifts the gap but never resizes it.
   a_move_size: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MOVE) |=> ($stable(gap_ff) && $stable(len_ff)))
      else $error("gap size changed during a cursor move");

   // Each move character that is read gets written in the following cycle.
   a_move_pend: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MOVE && left_ff != '0) |=> (pend_ff && state_ff == ST_MOVE))
      else $error("cursor move left a character unwritten");

   // Never offer a response while taking a new command.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid))
      else $error("request accepted while a response is pending");

endmodule

>>> design/gbts_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package needed.
module gbts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
